// ===== src/grm_pkg.sv =====
// grm_pkg: shared types, codes and constants of the grid ray march engine
`default_nettype none
package grm_pkg;
   localparam int MAP_COLUMNS_DEF = 128;
   localparam int MAP_ROWS_DEF    = 128;
   localparam int CELL_SHIFT      = 5;
   localparam int FRAC_BITS       = 14;
   localparam int POS_W           = 29;
   localparam int STEP_W          = 11;
   localparam int NUM_W           = 30;
   localparam int DEN_W           = 26;
   localparam int REM_W           = 27;
   localparam int TEX_W           = 9;
   localparam int TREM_W          = 10;
   localparam int DIV_CNT_W       = 5;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;

   localparam logic [15:0]       PROJ_SCALE_RST  = 16'd1000;
   localparam logic [STEP_W-1:0] MAX_CAST_RST    = 11'd1199;
   localparam logic [STEP_W-1:0] MAX_PLACE_RST   = 11'd251;
   localparam logic [TEX_W-1:0]  TEX_SIZE_RST    = 9'd16;
   localparam logic [TEX_W-1:0]  TEX_SIZE_MAX    = 9'd256;
   localparam logic [15:0]       HEIGHT_MAX      = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_CAST  = 2'd1,
      CMD_PLACE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_code_type;

   typedef enum logic [2:0] {
      ST_WRITTEN    = 3'd0,
      ST_CAST_HIT   = 3'd1,
      ST_CAST_MISS  = 3'd2,
      ST_PLACED     = 3'd3,
      ST_PLACE_MISS = 3'd4
   } status_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROJ_SCALE = 3'd0,
      CSR_MAX_CAST   = 3'd1,
      CSR_MAX_PLACE  = 3'd2,
      CSR_TEX_WIDTH  = 3'd3,
      CSR_TEX_HEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WRITE,
      S_MARCH,
      S_MUL,
      S_DIV,
      S_FIN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [6:0]         cell_x;
      logic [6:0]         cell_y;
      logic               cell_value;
      logic [19:0]        origin_x;
      logic [19:0]        origin_y;
      logic signed [15:0] dir_cos;
      logic signed [15:0] dir_sin;
      logic [14:0]        view_cos;
      logic [5:0]         column;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  column_out;
      logic [10:0] step_count;
      logic [15:0] wall_height;
      logic [7:0]  texture_offset;
      logic [6:0]  hit_cell_x;
      logic [6:0]  hit_cell_y;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic cell_write;
      logic march;
      logic mul;
      logic div_step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic cast_item;
      logic march_hit;
      logic march_miss;
      logic div_last;
   } dp_status_type;
endpackage
`default_nettype wire

// ===== src/grm_ctrl.sv =====
// grm_ctrl: sequencing state machine of the grid ray march engine
`default_nettype none
module grm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [1:0]              command,
   input  wire grm_pkg::dp_status_type  status,
   output grm_pkg::ctrl_cmd_type        cmd,
   output logic                         busy,
   output logic                         rsp_valid
);
   grm_pkg::state_type state_ff, state_in;
   logic               ready;

   assign ready = (state_ff == grm_pkg::S_IDLE) || (state_ff == grm_pkg::S_RESP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grm_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grm_pkg::S_CLEAR: begin
            if (status.clear_last) state_in = grm_pkg::S_IDLE;
         end
         grm_pkg::S_IDLE, grm_pkg::S_RESP: begin
            state_in = grm_pkg::S_IDLE;
            if (start) begin
               case (command)
                  grm_pkg::CMD_WRITE: state_in = grm_pkg::S_WRITE;
                  grm_pkg::CMD_CAST:  state_in = grm_pkg::S_MARCH;
                  grm_pkg::CMD_PLACE: state_in = grm_pkg::S_MARCH;
                  default:            state_in = grm_pkg::S_IDLE;
               endcase
            end
         end
         grm_pkg::S_WRITE: state_in = grm_pkg::S_RESP;
         grm_pkg::S_MARCH: begin
            if (status.march_hit) begin
               state_in = status.cast_item ? grm_pkg::S_MUL : grm_pkg::S_RESP;
            end else if (status.march_miss) begin
               state_in = grm_pkg::S_RESP;
            end
         end
         grm_pkg::S_MUL: state_in = grm_pkg::S_DIV;
         grm_pkg::S_DIV: begin
            if (status.div_last) state_in = grm_pkg::S_FIN;
         end
         grm_pkg::S_FIN: state_in = grm_pkg::S_RESP;
         default: state_in = grm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.load       = ready && start;
      cmd.clear      = (state_ff == grm_pkg::S_CLEAR);
      cmd.cell_write = (state_ff == grm_pkg::S_WRITE);
      cmd.march      = (state_ff == grm_pkg::S_MARCH);
      cmd.mul        = (state_ff == grm_pkg::S_MUL);
      cmd.div_step   = (state_ff == grm_pkg::S_DIV);
      cmd.finish     = (state_ff == grm_pkg::S_FIN);
      busy           = !ready;
      rsp_valid      = (state_ff == grm_pkg::S_RESP);
   end
endmodule
`default_nettype wire

// ===== src/grm_datapath.sv =====
// grm_datapath: occupancy map, ray stepping pipeline, divider and result register
`default_nettype none
module grm_datapath #(
   parameter int MAP_COLUMNS = grm_pkg::MAP_COLUMNS_DEF,
   parameter int MAP_ROWS    = grm_pkg::MAP_ROWS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire grm_pkg::ctrl_cmd_type              cmd,
   input  wire grm_pkg::req_type                   req,
   input  wire logic                               csr_write,
   input  wire logic [grm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [grm_pkg::CSR_DATA_W-1:0]     csr_data,
   output grm_pkg::dp_status_type                  status,
   output grm_pkg::rsp_type                        rsp
);
   localparam int DEPTH  = MAP_COLUMNS * MAP_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CX_W   = $clog2(MAP_COLUMNS);
   localparam int CY_W   = $clog2(MAP_ROWS);
   localparam int PX_W   = CX_W + grm_pkg::CELL_SHIFT;
   localparam int PY_W   = CY_W + grm_pkg::CELL_SHIFT;
   localparam int POS_W  = grm_pkg::POS_W;
   localparam int CF_LO  = grm_pkg::FRAC_BITS + grm_pkg::CELL_SHIFT;
   localparam int CF_W   = POS_W - 1 - CF_LO;
   localparam int STEP_W = grm_pkg::STEP_W;
   localparam int NUM_W  = grm_pkg::NUM_W;
   localparam int DEN_W  = grm_pkg::DEN_W;
   localparam int REM_W  = grm_pkg::REM_W;
   localparam int TEX_W  = grm_pkg::TEX_W;
   localparam int TREM_W = grm_pkg::TREM_W;

   // configuration
   logic [15:0]       proj_ff;
   logic [STEP_W-1:0] max_cast_ff, max_place_ff;
   logic [TEX_W-1:0]  tex_w_ff, tex_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_ff      <= grm_pkg::PROJ_SCALE_RST;
         max_cast_ff  <= grm_pkg::MAX_CAST_RST;
         max_place_ff <= grm_pkg::MAX_PLACE_RST;
         tex_w_ff     <= grm_pkg::TEX_SIZE_RST;
         tex_h_ff     <= grm_pkg::TEX_SIZE_RST;
      end else if (csr_write) begin
         case (csr_index)
            grm_pkg::CSR_PROJ_SCALE: proj_ff      <= csr_data;
            grm_pkg::CSR_MAX_CAST:   max_cast_ff  <= csr_data[STEP_W-1:0];
            grm_pkg::CSR_MAX_PLACE:  max_place_ff <= csr_data[STEP_W-1:0];
            grm_pkg::CSR_TEX_WIDTH:  tex_w_ff     <= csr_data[TEX_W-1:0];
            grm_pkg::CSR_TEX_HEIGHT: tex_h_ff     <= csr_data[TEX_W-1:0];
            default: ;
         endcase
      end
   end

   // item registers
   logic [1:0]              cmd_ff;
   logic [6:0]              cell_x_ff, cell_y_ff;
   logic                    cell_value_ff;
   logic signed [15:0]      dcos_ff, dsin_ff;
   logic [14:0]             vcos_ff;
   logic [STEP_W-1:0]       limit_ff;
   logic                    lim_zero_ff;

   // sample stage: address issue
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic [STEP_W-1:0]       ja_ff;
   logic                    a_live_ff;
   logic [CF_W-1:0]         cfx, cfy;
   logic                    a_ok;
   logic [CX_W-1:0]         a_cx;
   logic [CY_W-1:0]         a_cy;
   logic [ADDR_W-1:0]       a_addr;

   // probe stage: map bit returns
   logic                    b_valid_ff, b_ok_ff;
   logic [STEP_W-1:0]       b_j_ff;
   logic [CX_W-1:0]         b_cx_ff;
   logic [CY_W-1:0]         b_cy_ff;
   logic [PX_W-1:0]         b_px_ff;
   logic [PY_W-1:0]         b_py_ff;
   logic                    rd_ff;
   logic                    hit;

   logic                    prev_ok_ff;
   logic [CX_W-1:0]         pcx_ff;
   logic [CY_W-1:0]         pcy_ff;
   logic [6:0]              ocx, ocy;

   // divider lanes
   logic [PX_W-1:0]         hpx_ff;
   logic [PY_W-1:0]         hpy_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [NUM_W-1:0]        h_num_ff, h_q_ff, mx_num_ff, my_num_ff;
   logic [REM_W-1:0]        h_rem_ff, h_t;
   logic [TREM_W-1:0]       mx_rem_ff, my_rem_ff, mx_t, my_t;
   logic                    h_ge, mx_ge, my_ge;
   logic [grm_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [TEX_W-1:0]        twc, thc;

   // memory
   logic                    mem [DEPTH];
   logic [ADDR_W-1:0]       clr_ff, wa;
   logic                    we, wd, cell_inb, place_wr;

   grm_pkg::rsp_type        res_ff;

   function automatic logic [ADDR_W-1:0] map_addr(input logic [CX_W-1:0] x,
                                                 input logic [CY_W-1:0] y);
      return ADDR_W'(32'(y) * MAP_COLUMNS + 32'(x));
   endfunction

   function automatic logic [TEX_W-1:0] tex_clamp(input logic [TEX_W-1:0] t);
      logic [TEX_W-1:0] r;
      r = t;
      if (t == '0) r = TEX_W'(1);
      else if (t > grm_pkg::TEX_SIZE_MAX) r = grm_pkg::TEX_SIZE_MAX;
      return r;
   endfunction

   assign twc = tex_clamp(tex_w_ff);
   assign thc = tex_clamp(tex_h_ff);

   assign cfx    = pos_x_ff[POS_W-2:CF_LO];
   assign cfy    = pos_y_ff[POS_W-2:CF_LO];
   assign a_ok   = !pos_x_ff[POS_W-1] && !pos_y_ff[POS_W-1] &&
                   (32'(cfx) < MAP_COLUMNS) && (32'(cfy) < MAP_ROWS);
   assign a_cx   = CX_W'(cfx);
   assign a_cy   = CY_W'(cfy);
   assign a_addr = map_addr(a_cx, a_cy);

   assign hit = b_valid_ff && b_ok_ff && rd_ff;
   assign ocx = req.origin_x[19:13];
   assign ocy = req.origin_y[19:13];

   assign status.clear_last = (clr_ff == ADDR_W'(DEPTH - 1));
   assign status.cast_item  = (cmd_ff == grm_pkg::CMD_CAST);
   assign status.march_hit  = cmd.march && hit;
   assign status.march_miss = cmd.march &&
                              (lim_zero_ff || (b_valid_ff && !hit && b_j_ff == limit_ff));
   assign status.div_last   = (cnt_ff == grm_pkg::DIV_CNT_W'(NUM_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_live_ff  <= 1'b0;
         b_valid_ff <= 1'b0;
         clr_ff     <= '0;
      end else begin
         b_valid_ff <= cmd.march && a_live_ff;
         if (cmd.clear) clr_ff <= clr_ff + ADDR_W'(1);
         if (cmd.load) begin
            a_live_ff <= (req.command == grm_pkg::CMD_CAST) ? (max_cast_ff != '0)
                                                           : (max_place_ff != '0);
         end else if (cmd.march && a_live_ff) begin
            a_live_ff <= (ja_ff != limit_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff        <= req.command;
         cell_x_ff     <= req.cell_x;
         cell_y_ff     <= req.cell_y;
         cell_value_ff <= req.cell_value;
         dcos_ff       <= req.dir_cos;
         dsin_ff       <= req.dir_sin;
         vcos_ff       <= req.view_cos;
         limit_ff      <= (req.command == grm_pkg::CMD_CAST) ? max_cast_ff : max_place_ff;
         lim_zero_ff   <= (req.command == grm_pkg::CMD_CAST) ? (max_cast_ff == '0)
                                                            : (max_place_ff == '0);
         pos_x_ff      <= $signed({3'b000, req.origin_x, 6'b0}) + POS_W'(req.dir_cos);
         pos_y_ff      <= $signed({3'b000, req.origin_y, 6'b0}) + POS_W'(req.dir_sin);
         ja_ff         <= STEP_W'(1);
         prev_ok_ff    <= (32'(ocx) < MAP_COLUMNS) && (32'(ocy) < MAP_ROWS);
         pcx_ff        <= CX_W'(ocx);
         pcy_ff        <= CY_W'(ocy);
      end else if (cmd.march) begin
         pos_x_ff <= pos_x_ff + POS_W'(dcos_ff);
         pos_y_ff <= pos_y_ff + POS_W'(dsin_ff);
         ja_ff    <= ja_ff + STEP_W'(1);
         if (b_valid_ff && !hit) begin
            prev_ok_ff <= b_ok_ff;
            if (b_ok_ff) begin
               pcx_ff <= b_cx_ff;
               pcy_ff <= b_cy_ff;
            end
         end
      end
      b_ok_ff <= a_ok;
      b_j_ff  <= ja_ff;
      b_cx_ff <= a_cx;
      b_cy_ff <= a_cy;
      b_px_ff <= pos_x_ff[grm_pkg::FRAC_BITS +: PX_W];
      b_py_ff <= pos_y_ff[grm_pkg::FRAC_BITS +: PY_W];
   end

   // map port
   assign cell_inb = (32'(cell_x_ff) < MAP_COLUMNS) && (32'(cell_y_ff) < MAP_ROWS);
   assign place_wr = status.march_hit && (cmd_ff == grm_pkg::CMD_PLACE) && prev_ok_ff;

   always_comb begin
      we = 1'b0;
      wa = clr_ff;
      wd = 1'b0;
      if (cmd.clear) begin
         we = 1'b1;
      end else if (cmd.cell_write && cell_inb) begin
         we = 1'b1;
         wa = map_addr(CX_W'(cell_x_ff), CY_W'(cell_y_ff));
         wd = cell_value_ff;
      end else if (place_wr) begin
         we = 1'b1;
         wa = map_addr(pcx_ff, pcy_ff);
         wd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[a_addr];
   end

   // restoring division steps
   assign h_t   = {h_rem_ff[REM_W-2:0], h_num_ff[NUM_W-1]};
   assign h_ge  = (h_t >= {1'b0, den_ff});
   assign mx_t  = {mx_rem_ff[TREM_W-2:0], mx_num_ff[NUM_W-1]};
   assign mx_ge = (mx_t >= {1'b0, twc});
   assign my_t  = {my_rem_ff[TREM_W-2:0], my_num_ff[NUM_W-1]};
   assign my_ge = (my_t >= {1'b0, thc});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         den_ff    <= {15'b0, res_ff.step_count} * {11'b0, vcos_ff};
         h_num_ff  <= {proj_ff, 14'b0};
         h_rem_ff  <= '0;
         h_q_ff    <= '0;
         mx_num_ff <= NUM_W'(hpx_ff);
         my_num_ff <= NUM_W'(hpy_ff);
         mx_rem_ff <= '0;
         my_rem_ff <= '0;
         cnt_ff    <= '0;
      end else if (cmd.div_step) begin
         h_num_ff  <= {h_num_ff[NUM_W-2:0], 1'b0};
         h_rem_ff  <= h_ge ? h_t - {1'b0, den_ff} : h_t;
         h_q_ff    <= {h_q_ff[NUM_W-2:0], h_ge};
         mx_num_ff <= {mx_num_ff[NUM_W-2:0], 1'b0};
         mx_rem_ff <= mx_ge ? mx_t - {1'b0, twc} : mx_t;
         my_num_ff <= {my_num_ff[NUM_W-2:0], 1'b0};
         my_rem_ff <= my_ge ? my_t - {1'b0, thc} : my_t;
         cnt_ff    <= cnt_ff + grm_pkg::DIV_CNT_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff            <= '0;
         res_ff.column_out <= req.column;
      end else if (cmd.cell_write) begin
         res_ff.status <= grm_pkg::ST_WRITTEN;
      end else if (status.march_hit) begin
         if (cmd_ff == grm_pkg::CMD_CAST) begin
            res_ff.status     <= grm_pkg::ST_CAST_HIT;
            res_ff.step_count <= b_j_ff;
            res_ff.hit_cell_x <= 7'(b_cx_ff);
            res_ff.hit_cell_y <= 7'(b_cy_ff);
            hpx_ff            <= b_px_ff;
            hpy_ff            <= b_py_ff;
         end else if (prev_ok_ff) begin
            res_ff.status     <= grm_pkg::ST_PLACED;
            res_ff.step_count <= b_j_ff;
            res_ff.hit_cell_x <= 7'(pcx_ff);
            res_ff.hit_cell_y <= 7'(pcy_ff);
         end else begin
            res_ff.status <= grm_pkg::ST_PLACE_MISS;
         end
      end else if (status.march_miss) begin
         res_ff.status <= (cmd_ff == grm_pkg::CMD_CAST) ? grm_pkg::ST_CAST_MISS
                                                       : grm_pkg::ST_PLACE_MISS;
      end else if (cmd.finish) begin
         if (den_ff == '0 || h_q_ff[NUM_W-1:16] != '0) begin
            res_ff.wall_height <= grm_pkg::HEIGHT_MAX;
         end else begin
            res_ff.wall_height <= h_q_ff[15:0];
         end
         if (my_rem_ff == '0 || my_rem_ff == {1'b0, thc - TEX_W'(1)}) begin
            res_ff.texture_offset <= mx_rem_ff[7:0];
         end else if (mx_rem_ff == '0 || mx_rem_ff == {1'b0, twc - TEX_W'(1)}) begin
            res_ff.texture_offset <= my_rem_ff[7:0];
         end else begin
            res_ff.texture_offset <= '0;
         end
      end
   end

   assign rsp = res_ff;
endmodule
`default_nettype wire

// ===== src/grid_ray_march_engine.sv =====
// grid_ray_march_engine: top level of the grid ray march engine
//
// command channel: req is taken at a rising edge with start high and busy low;
// command write sets one map cell, cast steps a ray from its origin until the
// first occupied cell, place marks the cell sampled just before such a hit
// an unknown command is taken and gives no result
// each result sits on rsp for one cycle with rsp_valid high; the receiver
// cannot stall, and a new item may be started in that same cycle
// csr channel: csr_ready is always high, csr_index selects the register
// ray items: cast or place probe the map once a cycle, pipelined, and give the
// result after a hit at step j or a miss after a limit of j steps; a cast hit
// then passes through the height multiply, the 30-step restoring divide and the
// result update
// reset: configuration and state registers take their reset values and the map
// is swept clear one cell a cycle, all MAP_COLUMNS * MAP_ROWS cells, busy high
`default_nettype none
module grid_ray_march_engine #(
   parameter int MAP_COLUMNS = grm_pkg::MAP_COLUMNS_DEF,
   parameter int MAP_ROWS    = grm_pkg::MAP_ROWS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire grm_pkg::req_type                req,
   output logic                                 rsp_valid,
   output grm_pkg::rsp_type                     rsp,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [grm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [grm_pkg::CSR_DATA_W-1:0]  csr_data
);
   grm_pkg::ctrl_cmd_type  cmd;
   grm_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   grm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req.command),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   grm_datapath #(
      .MAP_COLUMNS (MAP_COLUMNS),
      .MAP_ROWS    (MAP_ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status),
      .rsp       (rsp)
   );

   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.command == grm_pkg::CMD_CAST) |=> busy)
      else $error("cast item did not start");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == grm_pkg::ST_CAST_MISS) |->
         (rsp.step_count == '0 && rsp.wall_height == '0))
      else $error("cast miss with nonzero fields");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of the grid ray march engine
`default_nettype none
module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   grm_pkg::req_type req = '0;
   logic rsp_valid;
   grm_pkg::rsp_type rsp;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [grm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [grm_pkg::CSR_DATA_W-1:0] csr_data = '0;

   grid_ray_march_engine i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit occ [0:16383];
   int unsigned scale_reg, cast_lim, place_lim, tex_w, tex_h;
   grm_pkg::rsp_type expected_rsps [$];
   int unsigned mismatches = 0, n_items = 0, n_hits = 0, n_places = 0, n_rsps = 0;

   function automatic bit probe(logic [19:0] o, logic signed [15:0] d, int unsigned j,
                                output longint unsigned pix);
      longint p;
      p = longint'({o, 6'b0}) + longint'(j) * longint'(d);
      pix = longint'(p) >>> 14;
      return p >= 0;
   endfunction

   function automatic bit cell_ok(longint unsigned px, longint unsigned py,
                                  output int unsigned cx, output int unsigned cy);
      cx = 32'(px >> 5);
      cy = 32'(py >> 5);
      return (px >> 5) < 128 && (py >> 5) < 128;
   endfunction

   function automatic int unsigned tex_clamp(int unsigned t);
      return t == 0 ? 1 : (t > 256 ? 256 : t);
   endfunction

   function automatic grm_pkg::rsp_type march_predict(grm_pkg::req_type r);
      grm_pkg::rsp_type o;
      longint unsigned px, py, den, h;
      int unsigned cx, cy, pcx, pcy, tw, th, offx, offy, off;
      bit ok, prev_ok;
      o = '0;
      o.column_out = r.column;
      if (r.command == grm_pkg::CMD_WRITE) begin
         occ[{r.cell_y, r.cell_x}] = r.cell_value;
         o.status = grm_pkg::ST_WRITTEN;
      end else if (r.command == grm_pkg::CMD_CAST) begin
         o.status = grm_pkg::ST_CAST_MISS;
         for (int unsigned j = 1; j <= cast_lim; j++) begin
            if (!probe(r.origin_x, r.dir_cos, j, px) ||
                !probe(r.origin_y, r.dir_sin, j, py))
               continue;
            if (!cell_ok(px, py, cx, cy) || !occ[cy * 128 + cx]) continue;
            den = longint'(j) * r.view_cos;
            h = 65535;
            if (den != 0) begin
               h = (longint'(scale_reg) << 14) / den;
               if (h > 65535) h = 65535;
            end
            tw = tex_clamp(tex_w);
            th = tex_clamp(tex_h);
            offx = 32'(px % tw);
            offy = 32'(py % th);
            off = 0;
            if (offx == 0 || offx == tw - 1) off = offy;
            if (offy == 0 || offy == th - 1) off = offx;
            o.status = grm_pkg::ST_CAST_HIT;
            o.step_count = 11'(j);
            o.wall_height = 16'(h);
            o.texture_offset = 8'(off);
            o.hit_cell_x = 7'(cx);
            o.hit_cell_y = 7'(cy);
            break;
         end
      end else begin
         o.status = grm_pkg::ST_PLACE_MISS;
         prev_ok = cell_ok(r.origin_x >> 8, r.origin_y >> 8, pcx, pcy);
         for (int unsigned j = 1; j <= place_lim; j++) begin
            ok = probe(r.origin_x, r.dir_cos, j, px) && probe(r.origin_y, r.dir_sin, j, py);
            if (ok) ok = cell_ok(px, py, cx, cy);
            if (ok && occ[cy * 128 + cx]) begin
               if (prev_ok) begin
                  occ[pcy * 128 + pcx] = 1'b1;
                  o.status = grm_pkg::ST_PLACED;
                  o.step_count = 11'(j);
                  o.hit_cell_x = 7'(pcx);
                  o.hit_cell_y = 7'(pcy);
               end
               break;
            end
            prev_ok = ok;
            if (ok) begin
               pcx = cx;
               pcy = cy;
            end
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      grm_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         n_rsps++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp);
         end else begin
            e = expected_rsps.pop_front();
            if (e.status == grm_pkg::ST_CAST_HIT) n_hits++;
            if (e.status == grm_pkg::ST_PLACED) n_places++;
            if (rsp !== e) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp);
            end
         end
      end
   end

   task automatic csr_write(grm_pkg::csr_index_type idx, int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= grm_pkg::CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         grm_pkg::CSR_PROJ_SCALE: scale_reg = value & 16'hFFFF;
         grm_pkg::CSR_MAX_CAST: cast_lim = value & 11'h7FF;
         grm_pkg::CSR_MAX_PLACE: place_lim = value & 11'h7FF;
         grm_pkg::CSR_TEX_WIDTH: tex_w = value & 9'h1FF;
         default: tex_h = value & 9'h1FF;
      endcase
   endtask

   int gap_left = 0;
   task automatic send_item(grm_pkg::req_type r);
      if (gap_left == 0 && $urandom_range(0, 5) == 0) begin
         gap_left = $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
         start <= 1'b0;
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end
      start <= 1'b1;
      req <= r;
      do @(posedge clock); while (busy);
      if (r.command != grm_pkg::CMD_NONE) begin
         expected_rsps.insert(expected_rsps.size(), march_predict(r));
      end
      n_items++;
   endtask

   task automatic drain;
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (1300) @(posedge clock);
   endtask

   function automatic grm_pkg::req_type ray_item(logic [1:0] c);
      grm_pkg::req_type r;
      r = '0;
      r.command = c;
      r.origin_x = 20'($urandom_range(0, 4095 * 256));
      r.origin_y = 20'($urandom_range(0, 4095 * 256));
      if ($urandom_range(0, 3) != 0) begin
         r.origin_x = 20'($urandom_range(0, 1200 * 256));
         r.origin_y = 20'($urandom_range(0, 1200 * 256));
      end
      r.dir_cos = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.dir_sin = 16'($signed($urandom_range(0, 32768)) - 16384);
      r.view_cos = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($urandom_range(0, 16384));
      r.column = 6'($urandom);
      r.cell_x = 7'($urandom);
      r.cell_y = 7'($urandom);
      r.cell_value = 1'($urandom);
      return r;
   endfunction

   function automatic grm_pkg::req_type write_item(int x, int y, bit v);
      grm_pkg::req_type r;
      r = ray_item(grm_pkg::CMD_WRITE);
      r.cell_x = 7'(x);
      r.cell_y = 7'(y);
      r.cell_value = v;
      return r;
   endfunction

   typedef struct {
      grm_pkg::req_type r;
      bit known;
      grm_pkg::rsp_type e;
   } stim_row_type;

   stim_row_type rows [$];

   function automatic void add_row(grm_pkg::req_type r, bit known, grm_pkg::rsp_type e);
      stim_row_type row;
      row.r = r;
      row.known = known;
      row.e = e;
      rows.insert(rows.size(), row);
   endfunction

   initial begin
      stim_row_type row;
      grm_pkg::req_type r;
      grm_pkg::rsp_type e;
      foreach (occ[i]) occ[i] = 1'b0;
      scale_reg = 1000; cast_lim = 1199; place_lim = 251; tex_w = 16; tex_h = 16;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // cast into an empty map misses
      r = '0; r.command = grm_pkg::CMD_CAST; r.origin_x = 20'hFFFFF; r.origin_y = 20'hFFFFF;
      r.dir_cos = -16'sd16384; r.dir_sin = 16'sd16384; r.view_cos = 15'h7FFF;
      r.column = 6'd63;
      e = '0; e.status = grm_pkg::ST_CAST_MISS; e.column_out = 6'd63;
      add_row(r, 1'b1, e);
      r = write_item(127, 127, 1'b1); r.column = 6'd0;
      e = '0; e.status = grm_pkg::ST_WRITTEN;
      add_row(r, 1'b1, e);
      r = write_item(10, 5, 1'b1); add_row(r, 1'b0, '0);
      r = write_item(0, 0, 1'b1); add_row(r, 1'b0, '0);
      // cast along x into cell (10,5), zero view cosine
      r = '0; r.command = grm_pkg::CMD_CAST; r.origin_x = 20'd48 << 8;
      r.origin_y = 20'd170 << 8;
      r.dir_cos = 16'sd16384; r.view_cos = 15'd0; r.column = 6'd7;
      add_row(r, 1'b0, '0);
      r.view_cos = 15'd16384; r.column = 6'd8; add_row(r, 1'b0, '0);
      r.dir_cos = 16'sd11585; r.dir_sin = 16'sd11585; r.view_cos = 15'd1;
      add_row(r, 1'b0, '0);
      // place along the same ray, and place with hit at first step from an occupied origin
      r.command = grm_pkg::CMD_PLACE; r.dir_cos = 16'sd16384; r.dir_sin = 16'sd0;
      add_row(r, 1'b0, '0);
      r.origin_x = 20'd10; r.origin_y = 20'd10; r.dir_cos = 16'sd1; add_row(r, 1'b0, '0);
      r.dir_cos = -16'sd16384; r.dir_sin = -16'sd16384; add_row(r, 1'b0, '0);
      r.command = grm_pkg::CMD_NONE; add_row(r, 1'b0, '0);
      r = write_item(0, 0, 1'b0); add_row(r, 1'b0, '0);
      r = '0; r.command = grm_pkg::CMD_PLACE; r.origin_x = 20'hFFFFF;
      r.origin_y = 20'd170 << 8;
      r.dir_cos = -16'sd16384; add_row(r, 1'b0, '0);
      foreach (rows[i]) begin
         row = rows[i];
         send_item(row.r);
         if (row.known) begin
            e = expected_rsps.pop_back();
            if (e !== row.e) begin
               mismatches++;
               if (mismatches <= 10) $display("table row %0d: %p vs %p", i, row.e, e);
            end
            expected_rsps.insert(expected_rsps.size(), row.e);
         end
      end
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               csr_write(grm_pkg::CSR_PROJ_SCALE, 65535);
               csr_write(grm_pkg::CSR_MAX_CAST, 2047);
               csr_write(grm_pkg::CSR_MAX_PLACE, 2047);
               csr_write(grm_pkg::CSR_TEX_WIDTH, 256);
               csr_write(grm_pkg::CSR_TEX_HEIGHT, 256);
            end
            2: begin
               csr_write(grm_pkg::CSR_PROJ_SCALE, 0);
               csr_write(grm_pkg::CSR_MAX_CAST, 1);
               csr_write(grm_pkg::CSR_MAX_PLACE, 1);
               csr_write(grm_pkg::CSR_TEX_WIDTH, 1);
               csr_write(grm_pkg::CSR_TEX_HEIGHT, 0);
            end
            3: begin
               csr_write(grm_pkg::CSR_MAX_CAST, 0);
               csr_write(grm_pkg::CSR_MAX_PLACE, 0);
               csr_write(grm_pkg::CSR_TEX_WIDTH, 511);
               csr_write(grm_pkg::CSR_TEX_HEIGHT, 257);
            end
            default: begin
               csr_write(grm_pkg::CSR_PROJ_SCALE, $urandom);
               csr_write(grm_pkg::CSR_MAX_CAST, $urandom_range(1, 400));
               csr_write(grm_pkg::CSR_MAX_PLACE, $urandom_range(1, 300));
               csr_write(grm_pkg::CSR_TEX_WIDTH, $urandom_range(0, 511));
               csr_write(grm_pkg::CSR_TEX_HEIGHT, $urandom_range(0, 511));
            end
         endcase
         repeat (80) begin
            case ($urandom_range(0, 9))
               0, 1, 2: r = write_item($urandom_range(0, 40), $urandom_range(0, 40),
                                       $urandom_range(0, 4) != 0);
               3: r = write_item($urandom, $urandom, 1'($urandom));
               4, 5, 6: r = ray_item(grm_pkg::CMD_CAST);
               7, 8: r = ray_item(grm_pkg::CMD_PLACE);
               default: r = ray_item(2'($urandom));
            endcase
            send_item(r);
         end
         drain();
      end

      $display("%0d items sent, %0d results, %0d cast hits, %0d placements, 6 settings",
               n_items, n_rsps, n_hits, n_places);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("grid_ray_march_engine test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("grid_ray_march_engine test failed");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("grid_ray_march_engine test failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
src/grm_pkg.sv
src/grm_ctrl.sv
src/grm_datapath.sv
src/grid_ray_march_engine.sv
tb/tb_top.sv
